// ===== hw/rtl/rtt_est_pkg.sv =====
`timescale 1ns / 1ps

package rtt_est_pkg;

  localparam int EST_W       = 40;
  localparam int TMO_W       = 48;
  localparam int CNT_W       = 5;
  localparam int FACT_W      = 8;
  localparam int ACT_W       = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 320;

  // Item actions (carried on s_tuser)
  localparam logic [ACT_W-1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET_PROBE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET_HS    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ACK_CAP     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRANULARITY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_RTT    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CONG_FACTOR = 2'd3;

  localparam logic [EST_W-1:0]  RST_ACK_CAP     = 40'd25000000;
  localparam logic [EST_W-1:0]  RST_GRANULARITY = 40'd1000000;
  localparam logic [EST_W-1:0]  RST_INIT_RTT    = 40'd100000000;
  localparam logic [FACT_W-1:0] RST_CONG_FACTOR = 8'd2;

  localparam logic [TMO_W-1:0] TMO_MAX = {TMO_W{1'b1}};

  typedef struct packed {
    logic [EST_W-1:0] smoothed;
    logic [EST_W-1:0] variation;
    logic [EST_W-1:0] minimum;
    logic [EST_W-1:0] latest;
    logic [CNT_W-1:0] probe_cnt;
    logic [CNT_W-1:0] hs_cnt;
    logic             seen;
  } est_snap_t;

endpackage

// ===== hw/rtl/rtt_estimator_probe_timeout_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser: action; s_tdata: sample, ack delay, count
// m_*      out  m_tvalid/m_tready  m_tdata: estimates, three timeouts, both counts
// cfg_*    in   cfg_en             cfg_addr selects register, cfg_data is the value
//
// One item per cycle without output stalls; results pass input, snapshot, result regs.
// The estimator state updates as an item leaves the input register; the timeouts,
// saturating shifts and congestion multiply are computed in the following stage.
// rst (synchronous) empties all stages, clears the estimates and loads register defaults.
// A stalled output holds its result; the stages behind it fill before s_tready drops.

module rtt_estimator_probe_timeout_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [39:0] rtt_sample, [79:40] reported ack delay, [84:80] new_count, [87:85] zero
  input  logic [rtt_est_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [1:0] action
  input  logic [rtt_est_pkg::ACT_W-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [39:0] smoothed, [79:40] variation, [119:80] minimum, [159:120] last_sample,
  // [207:160] probe_timeout, [255:208] handshake_timeout,
  // [303:256] congestion_duration, [308:304] probe_backoff,
  // [313:309] handshake_backoff, [319:314] zero
  output logic [rtt_est_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                                 cfg_en,
  input  logic [rtt_est_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rtt_est_pkg::EST_W-1:0]        cfg_data
);

  localparam int EW = rtt_est_pkg::EST_W;
  localparam int TW = rtt_est_pkg::TMO_W;
  localparam int CW = rtt_est_pkg::CNT_W;
  localparam int FW = rtt_est_pkg::FACT_W;

  // shift left by a backoff count, clamp to all ones on overflow
  function automatic logic [TW-1:0] sat_shift(input logic [EW+2:0] v,
                                              input logic [CW-1:0] cnt);
    logic [EW+2+31:0] wide;
    wide = {31'b0, v} << cnt;
    if (|wide[EW+2+31:TW]) begin
      return rtt_est_pkg::TMO_MAX;
    end
    return wide[TW-1:0];
  endfunction

  // configuration registers
  logic [EW-1:0] ack_cap;
  logic [EW-1:0] granularity;
  logic [EW-1:0] init_rtt;
  logic [FW-1:0] cong_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_cap     <= rtt_est_pkg::RST_ACK_CAP;
      granularity <= rtt_est_pkg::RST_GRANULARITY;
      init_rtt    <= rtt_est_pkg::RST_INIT_RTT;
      cong_factor <= rtt_est_pkg::RST_CONG_FACTOR;
    end else if (cfg_en) begin
      case (cfg_addr)
        rtt_est_pkg::REG_ACK_CAP:     ack_cap     <= cfg_data;
        rtt_est_pkg::REG_GRANULARITY: granularity <= cfg_data;
        rtt_est_pkg::REG_INIT_RTT:    init_rtt    <= cfg_data;
        rtt_est_pkg::REG_CONG_FACTOR: cong_factor <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic a_valid, b_valid, c_valid;
  logic load_a, load_b, load_c;

  assign load_c   = b_valid && (!c_valid || m_tready);
  assign load_b   = a_valid && (!b_valid || load_c);
  assign s_tready = !a_valid || load_b;
  assign load_a   = s_tvalid && s_tready;
  assign m_tvalid = c_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= load_a || (a_valid && !load_b);
      b_valid <= load_b || (b_valid && !load_c);
      c_valid <= load_c || (c_valid && !m_tready);
    end
  end

  // input register
  logic [rtt_est_pkg::ACT_W-1:0] a_action;
  logic [EW-1:0]                 a_sample;
  logic [EW-1:0]                 a_delay;
  logic [CW-1:0]                 a_count;

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_action <= s_tuser;
      a_sample <= s_tdata[EW-1:0];
      a_delay  <= s_tdata[2*EW-1:EW];
      a_count  <= s_tdata[2*EW+CW-1:2*EW];
    end
  end

  // estimator state
  rtt_est_pkg::est_snap_t est, est_next;

  logic [EW-1:0] min_cand;
  logic [EW-1:0] delay_clip;
  logic [EW:0]   min_plus;
  logic [EW-1:0] adjusted;
  logic [EW-1:0] diff;
  logic [EW+1:0] var_sum;
  logic [EW+2:0] sm_sum;

  always_comb begin
    min_cand   = (a_sample < est.minimum) ? a_sample : est.minimum;
    delay_clip = (a_delay > ack_cap) ? ack_cap : a_delay;
    min_plus   = {1'b0, min_cand} + {1'b0, delay_clip};
    adjusted   = ({1'b0, a_sample} > min_plus) ? (a_sample - delay_clip) : a_sample;
    diff       = (est.smoothed > adjusted) ? (est.smoothed - adjusted)
                                           : (adjusted - est.smoothed);
    var_sum    = {2'b0, est.variation} + {1'b0, est.variation, 1'b0} + {2'b0, diff};
    sm_sum     = {est.smoothed, 3'b0} - {3'b0, est.smoothed} + {3'b0, adjusted};

    est_next = est;
    case (a_action)
      rtt_est_pkg::ACT_SAMPLE: begin
        est_next.latest = a_sample;
        if (!est.seen) begin
          est_next.seen      = 1'b1;
          est_next.smoothed  = a_sample;
          est_next.variation = {1'b0, a_sample[EW-1:1]};
          est_next.minimum   = a_sample;
        end else begin
          est_next.minimum   = min_cand;
          est_next.variation = var_sum[EW+1:2];
          est_next.smoothed  = sm_sum[EW+2:3];
        end
      end
      rtt_est_pkg::ACT_SET_PROBE: est_next.probe_cnt = a_count;
      rtt_est_pkg::ACT_SET_HS:    est_next.hs_cnt    = a_count;
      rtt_est_pkg::ACT_CLEAR:     est_next = '0;
      default:                    est_next = est;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
    end else if (load_b) begin
      est <= est_next;
    end
  end

  // snapshot of the updated state for the timeout stage
  rtt_est_pkg::est_snap_t b_snap;

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_snap <= est_next;
    end
  end

  // timeouts
  logic [EW+1:0]   var4;
  logic [EW+2:0]   pto_sum;
  logic [EW+2:0]   pto_base;
  logic [EW:0]     hs_dbl;
  logic [EW:0]     hs_base;
  logic [EW+1:0]   cong_var;
  logic [EW+2:0]   cong_sum;
  logic [EW+2+FW:0] cong_prod;
  logic [TW-1:0]   pto, hs, cong;

  always_comb begin
    var4     = {b_snap.variation, 2'b0};
    pto_sum  = {3'b0, b_snap.smoothed} + {1'b0, var4} + {3'b0, ack_cap};
    pto_base = (pto_sum > {3'b0, granularity}) ? pto_sum : {3'b0, granularity};
    pto      = sat_shift(pto_base, b_snap.probe_cnt);

    hs_dbl   = b_snap.seen ? {b_snap.smoothed, 1'b0} : {init_rtt, 1'b0};
    hs_base  = (hs_dbl > {1'b0, granularity}) ? hs_dbl : {1'b0, granularity};
    hs       = sat_shift({2'b0, hs_base}, b_snap.hs_cnt);

    cong_var  = (var4 > {2'b0, granularity}) ? var4 : {2'b0, granularity};
    cong_sum  = {3'b0, b_snap.smoothed} + {1'b0, cong_var};
    cong_prod = {{FW{1'b0}}, cong_sum} * {{(EW+3){1'b0}}, cong_factor};
    cong      = (|cong_prod[EW+2+FW:TW]) ? rtt_est_pkg::TMO_MAX : cong_prod[TW-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_c) begin
      m_tdata <= {6'b0, b_snap.hs_cnt, b_snap.probe_cnt, cong, hs, pto,
                  b_snap.latest, b_snap.minimum, b_snap.variation, b_snap.smoothed};
    end
  end

endmodule

// ===== hw/rtl/rtt_est_checker.sv =====
`timescale 1ns / 1ps

module rtt_est_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [rtt_est_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // outputs empty right after reset
  assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // with the output side empty the stages behind it cannot be full
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // the minimum never exceeds the latest sample
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[119:80] <= m_tdata[159:120])
    else $error("minimum above latest sample");

endmodule

bind rtt_estimator_probe_timeout_top rtt_est_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/rtt_estimator_probe_timeout_top_tb.sv =====
`timescale 1ns / 1ps

module rtt_estimator_probe_timeout_top_tb;

  localparam int EST_W       = rtt_est_pkg::EST_W;
  localparam int TMO_W       = rtt_est_pkg::TMO_W;
  localparam int CNT_W       = rtt_est_pkg::CNT_W;
  localparam int ACT_W       = rtt_est_pkg::ACT_W;
  localparam int FACT_W      = rtt_est_pkg::FACT_W;
  localparam int CFG_ADDR_W  = rtt_est_pkg::CFG_ADDR_W;
  localparam int IN_TDATA_W  = rtt_est_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = rtt_est_pkg::OUT_TDATA_W;

  localparam int LIMIT_CYCLES = 300000;
  localparam logic [63:0] TMO_MAX64 = {16'b0, rtt_est_pkg::TMO_MAX};

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [EST_W-1:0] sample;
    logic [EST_W-1:0] ack_dly;
    logic [CNT_W-1:0] count;
  } rtt_item_t;

  typedef struct {
    logic [EST_W-1:0] smoothed;
    logic [EST_W-1:0] variation;
    logic [EST_W-1:0] minimum;
    logic [EST_W-1:0] last_sample;
    logic [TMO_W-1:0] probe_tmo;
    logic [TMO_W-1:0] hs_tmo;
    logic [TMO_W-1:0] cong_dur;
    logic [CNT_W-1:0] probe_cnt;
    logic [CNT_W-1:0] hs_cnt;
  } rtt_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [EST_W-1:0]       cfg_data = '0;

  rtt_estimator_probe_timeout_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Register copies
  logic [EST_W-1:0]  max_ack_cfg  = rtt_est_pkg::RST_ACK_CAP;
  logic [EST_W-1:0]  gran_cfg     = rtt_est_pkg::RST_GRANULARITY;
  logic [EST_W-1:0]  init_rtt_cfg = rtt_est_pkg::RST_INIT_RTT;
  logic [FACT_W-1:0] factor_cfg   = rtt_est_pkg::RST_CONG_FACTOR;

  // Estimator state copies
  logic [EST_W-1:0] est_smoothed  = '0;
  logic [EST_W-1:0] est_variation = '0;
  logic [EST_W-1:0] est_minimum   = '0;
  logic [EST_W-1:0] est_latest    = '0;
  logic [CNT_W-1:0] est_probe_cnt = '0;
  logic [CNT_W-1:0] est_hs_cnt    = '0;
  logic             est_seen      = 1'b0;

  rtt_item_t   pending_items[$];
  rtt_result_t expected_results[$];
  rtt_item_t   cur_item;

  int  items_pushed = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  cycle_cnt = 0;
  logic in_fire = 1'b0;
  bit  idle_on = 1'b1;
  bit  rx_hold_go = 1'b0;

  function automatic logic [63:0] backoff_shift(input logic [63:0] v, input logic [CNT_W-1:0] n);
    if (v > (TMO_MAX64 >> n))
      return TMO_MAX64;
    return v << n;
  endfunction

  function automatic rtt_result_t predict_estimates(input rtt_item_t it);
    logic [63:0] adj, diff, dly, s64, v64, pto, hs, base, cong, v4, g64;
    rtt_result_t r;
    case (it.action)
      rtt_est_pkg::ACT_SAMPLE: begin
        est_latest = it.sample;
        if (!est_seen) begin
          est_seen      = 1'b1;
          est_smoothed  = it.sample;
          est_variation = it.sample >> 1;
          est_minimum   = it.sample;
        end else begin
          if (it.sample < est_minimum)
            est_minimum = it.sample;
          dly = (it.ack_dly < max_ack_cfg) ? it.ack_dly : max_ack_cfg;
          adj = it.sample;
          // subtract the ack delay only when the result stays above the minimum
          if (adj > {24'b0, est_minimum} + dly)
            adj = adj - dly;
          s64 = est_smoothed;
          v64 = est_variation;
          diff = (s64 > adj) ? s64 - adj : adj - s64;
          v64 = (64'd3 * v64 + diff) >> 2;
          s64 = (64'd7 * s64 + adj) >> 3;
          est_variation = v64[EST_W-1:0];
          est_smoothed  = s64[EST_W-1:0];
        end
      end
      rtt_est_pkg::ACT_SET_PROBE: est_probe_cnt = it.count;
      rtt_est_pkg::ACT_SET_HS:    est_hs_cnt = it.count;
      default: begin
        est_smoothed  = '0;
        est_variation = '0;
        est_minimum   = '0;
        est_latest    = '0;
        est_probe_cnt = '0;
        est_hs_cnt    = '0;
        est_seen      = 1'b0;
      end
    endcase

    s64 = est_smoothed;
    v64 = est_variation;
    g64 = gran_cfg;
    pto = s64 + (v64 << 2) + {24'b0, max_ack_cfg};
    if (pto < g64)
      pto = g64;
    pto = backoff_shift(pto, est_probe_cnt);

    base = est_seen ? s64 : {24'b0, init_rtt_cfg};
    hs = base << 1;
    if (hs < g64)
      hs = g64;
    hs = backoff_shift(hs, est_hs_cnt);

    v4 = v64 << 2;
    if (v4 < g64)
      v4 = g64;
    cong = (s64 + v4) * {56'b0, factor_cfg};
    if (cong > TMO_MAX64)
      cong = TMO_MAX64;

    r.smoothed    = est_smoothed;
    r.variation   = est_variation;
    r.minimum     = est_minimum;
    r.last_sample = est_latest;
    r.probe_tmo   = pto[TMO_W-1:0];
    r.hs_tmo      = hs[TMO_W-1:0];
    r.cong_dur    = cong[TMO_W-1:0];
    r.probe_cnt   = est_probe_cnt;
    r.hs_cnt      = est_hs_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("result %0d %s: got 0x%0h, want 0x%0h", results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    rtt_result_t got, want;
    got.smoothed    = data[39:0];
    got.variation   = data[79:40];
    got.minimum     = data[119:80];
    got.last_sample = data[159:120];
    got.probe_tmo   = data[207:160];
    got.hs_tmo      = data[255:208];
    got.cong_dur    = data[303:256];
    got.probe_cnt   = data[308:304];
    got.hs_cnt      = data[313:309];
    if (expected_results.size() == 0) begin
      report_mismatch("transfer with nothing expected", 64'd0, 64'd0);
    end else begin
      want = expected_results.pop_front();
      if (got.smoothed !== want.smoothed)
        report_mismatch("smoothed", got.smoothed, want.smoothed);
      if (got.variation !== want.variation)
        report_mismatch("variation", got.variation, want.variation);
      if (got.minimum !== want.minimum)
        report_mismatch("minimum", got.minimum, want.minimum);
      if (got.last_sample !== want.last_sample)
        report_mismatch("last_sample", got.last_sample, want.last_sample);
      if (got.probe_tmo !== want.probe_tmo)
        report_mismatch("probe_timeout", got.probe_tmo, want.probe_tmo);
      if (got.hs_tmo !== want.hs_tmo)
        report_mismatch("handshake_timeout", got.hs_tmo, want.hs_tmo);
      if (got.cong_dur !== want.cong_dur)
        report_mismatch("congestion_duration", got.cong_dur, want.cong_dur);
      if (got.probe_cnt !== want.probe_cnt)
        report_mismatch("probe_backoff", got.probe_cnt, want.probe_cnt);
      if (got.hs_cnt !== want.hs_cnt)
        report_mismatch("handshake_backoff", got.hs_cnt, want.hs_cnt);
    end
  endtask

  // Predict on input transfers, check output transfers, watch the cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("** rtt_estimator_probe_timeout_top: FAILED **");
      $finish;
    end
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      check_result(m_tdata);
      results_seen <= results_seen + 1;
    end
    if (!rst && s_tvalid && s_tready)
      expected_results.insert(expected_results.size(), predict_estimates(cur_item));
  end

  // Input driver
  int tx_gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (in_fire || !s_tvalid) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        tx_gap_left = $urandom_range(1, 18) - 1;
        s_tvalid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        s_tdata  <= {3'b0, cur_item.count, cur_item.ack_dly, cur_item.sample};
        s_tuser  <= cur_item.action;
        s_tvalid <= 1'b1;
      end
    end
  end

  // Output receiver
  int rx_stall_left = 0;
  int rx_hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_go) begin
      // long back-pressure so the pipeline fills and stalls the input
      rx_hold_go = 1'b0;
      rx_hold_left = 150;
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_stall_left = $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [EST_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[EST_W-1:0];
  endfunction

  function automatic rtt_item_t mk_item(input logic [ACT_W-1:0] action,
                                        input logic [EST_W-1:0] sample,
                                        input logic [EST_W-1:0] ack_dly,
                                        input logic [CNT_W-1:0] count);
    rtt_item_t it;
    it.action  = action;
    it.sample  = sample;
    it.ack_dly = ack_dly;
    it.count   = count;
    return it;
  endfunction

  function automatic rtt_item_t rand_item(input logic [31:0] base);
    rtt_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.action = (sel < 70) ? rtt_est_pkg::ACT_SAMPLE :
                (sel < 82) ? rtt_est_pkg::ACT_SET_PROBE :
                (sel < 95) ? rtt_est_pkg::ACT_SET_HS : rtt_est_pkg::ACT_CLEAR;
    it.count = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                             5'($urandom_range(0, 6));
    if (it.action != rtt_est_pkg::ACT_SAMPLE) begin
      // payload is ignored for these actions; fill it with noise
      it.sample  = rand40();
      it.ack_dly = rand40();
      return it;
    end
    case ($urandom_range(0, 15))
      0:       it.sample = '0;
      1:       it.sample = '1;
      2, 3:    it.sample = rand40();
      4, 5:    it.sample = base - $urandom_range(0, base >> 3);
      default: it.sample = base + $urandom_range(0, base >> 1);
    endcase
    case ($urandom_range(0, 7))
      0:       it.ack_dly = '0;
      1:       it.ack_dly = '1;
      2:       it.ack_dly = rand40();
      default: it.ack_dly = $urandom_range(0, base >> 1);
    endcase
    return it;
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [EST_W-1:0] val);
    @(negedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      rtt_est_pkg::REG_ACK_CAP:     max_ack_cfg = val;
      rtt_est_pkg::REG_GRANULARITY: gran_cfg = val;
      rtt_est_pkg::REG_INIT_RTT:    init_rtt_cfg = val;
      rtt_est_pkg::REG_CONG_FACTOR: factor_cfg = val[FACT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic cfg_all(input logic [EST_W-1:0] max_ack, input logic [EST_W-1:0] gran,
                         input logic [EST_W-1:0] init_rtt, input logic [FACT_W-1:0] factor);
    cfg_write(rtt_est_pkg::REG_ACK_CAP, max_ack);
    cfg_write(rtt_est_pkg::REG_GRANULARITY, gran);
    cfg_write(rtt_est_pkg::REG_INIT_RTT, init_rtt);
    cfg_write(rtt_est_pkg::REG_CONG_FACTOR, {32'b0, factor});
  endtask

  function automatic logic [EST_W-1:0] rand_cfg40();
    case ($urandom_range(0, 3))
      0:       return rand40();
      1:       return $urandom_range(0, 1000);
      default: return $urandom_range(0, 60_000_000);
    endcase
  endfunction

  // wait until every pushed item has come back as a result
  task automatic drain();
    wait (results_seen == items_pushed);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input rtt_item_t it);
    pending_items.insert(pending_items.size(), it);
    items_pushed++;
  endtask

  task automatic run_random(input int n, input bit hold_rx);
    logic [31:0] base;
    base = $urandom_range(1000, 2_000_000_000);
    @(posedge clk);
    if (hold_rx)
      rx_hold_go = 1'b1;
    repeat (n) push_item(rand_item(base));
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: counts before any sample, first sample, clipping, clear
    push_item(mk_item(rtt_est_pkg::ACT_SET_HS, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SET_PROBE, '1, '1, 5'd31));
    push_item(mk_item(rtt_est_pkg::ACT_SET_HS, '1, '1, 5'd31));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd10_000_000, 40'd5_000_000, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd30_000_000, '1, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd60_000_000, '1, 5'd31));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd1_000_000, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd2_000_000, 40'd1_500_000, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, '1, '1, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SET_PROBE, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SET_HS, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_CLEAR, '1, '1, 5'd31));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, '0, '1, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, '1, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_CLEAR, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, '1, '1, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SET_PROBE, '0, '0, 5'd3));
    push_item(mk_item(rtt_est_pkg::ACT_SET_HS, '0, '0, 5'd5));
    push_item(mk_item(rtt_est_pkg::ACT_SAMPLE, 40'd100_000_000, 40'd20_000_000, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_CLEAR, '0, '0, 5'd0));
    push_item(mk_item(rtt_est_pkg::ACT_SET_PROBE, '0, '0, 5'd12));
    push_item(mk_item(rtt_est_pkg::ACT_SET_HS, '0, '0, 5'd20));
    drain();

    cfg_all('0, '0, '0, 8'd0);
    run_random(110, 1'b0);

    cfg_all('1, '1, '1, 8'd255);
    run_random(110, 1'b0);

    cfg_all(rand_cfg40(), rand_cfg40(), rand_cfg40(), 8'($urandom_range(0, 255)));
    run_random(160, 1'b1);

    cfg_all(rand_cfg40(), rand_cfg40(), rand40(), 8'($urandom_range(0, 255)));
    run_random(160, 1'b0);

    cfg_all(rand_cfg40(), $urandom_range(0, 100), rand_cfg40(), 8'd1);
    run_random(160, 1'b0);

    idle_on = 1'b0;
    cfg_all(rtt_est_pkg::RST_ACK_CAP, rtt_est_pkg::RST_GRANULARITY,
            rtt_est_pkg::RST_INIT_RTT, rtt_est_pkg::RST_CONG_FACTOR);
    run_random(130, 1'b0);

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("expectations left over", expected_results.size(), 64'd0);
    if (mismatches == 0)
      $display("** rtt_estimator_probe_timeout_top: PASSED **");
    else
      $display("** rtt_estimator_probe_timeout_top: FAILED **");
    $finish;
  end

endmodule
